// ===== hdl/snfs_pkg.sv =====
// ----------------------------------------------------------------------------
// snfs_pkg
// Shared types and constants for the sparse forward-substitution solver.
// ----------------------------------------------------------------------------
package snfs_pkg;

  localparam int unsigned MaxRows  = 4096;
  localparam int unsigned MaxTerms = 32;
  localparam int unsigned FracBits = 16;

  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned TermW = $clog2(MaxTerms) + 1;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNSOLVED  = 3'd1,
    ERR_ZERO_DIAG = 3'd2,
    ERR_TOO_MANY  = 3'd3,
    ERR_ORDER     = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== hdl/snfs_ram.sv =====
// ----------------------------------------------------------------------------
// snfs_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module snfs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/sparse_neighbor_forward_solve_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_neighbor_forward_solve_unit
// Sparse lower-triangular forward substitution, Q16.16, one word per item.
// ----------------------------------------------------------------------------
// Steps: a start word is taken in idle; a term word passes through store read,
//   multiply and accumulate; a last word adds a restoring divide plus output.
// Throughput: one word at a time; the bit-serial divider sets the row tail.
// Reset: control state and row state clear at once; the solution store is
//   not cleared and holds garbage until a row writes it.
// ----------------------------------------------------------------------------
module sparse_neighbor_forward_solve_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [12:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic signed [31:0]        rhs_value_i,
  input  logic signed [31:0]        coeff_i,
  input  logic [11:0]               neighbor_row_i,
  input  logic                      row_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [11:0]               row_index_o,
  output logic signed [31:0]        solution_o,
  output logic                      solve_done_o,
  output logic [2:0]                error_code_o
);
  import snfs_pkg::*;

  localparam logic signed [63:0] S64Max = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64Min = {1'b1, {63{1'b0}}};

  state_e state_q, state_d;

  logic [12:0]        rows_cfg_q;
  logic [RowW-1:0]    row_q;
  logic signed [63:0] sum_q;
  logic signed [31:0] diag_q;
  logic [TermW-1:0]   terms_q;
  logic               open_q;
  err_e               fault_q;

  // held copy of the accepted word
  logic               last_q;
  logic signed [31:0] cf_q;
  logic [RowW-1:0]    nb_q;
  logic signed [63:0] prod_q;

  // divider
  logic [63:0]        dnum_q;   // magnitude of numerator, shifts out
  logic [32:0]        drem_q;
  logic [63:0]        dquo_q;
  logic [6:0]         dcnt_q;
  logic               dneg_q;

  logic [31:0]        sol_q;
  logic               done_q;
  logic [RowW-1:0]    orow_q;
  err_e               oerr_q;
  logic               ovalid_q;

  logic [31:0] rd_data;
  logic        store_we;

  logic accept;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !ovalid_q;

  // effective row count: 0 acts as 1, clamp to MaxRows
  logic [12:0] rows_eff;
  always_comb begin
    rows_eff = rows_cfg_q;
    if (rows_cfg_q == 13'd0) rows_eff = 13'd1;
    else if (rows_cfg_q > 13'(MaxRows)) rows_eff = 13'(MaxRows);
  end

  logic [31:0] abs_diag;
  assign abs_diag = diag_q[31] ? 32'(-diag_q) : 32'(diag_q);

  // one restoring step of the divider
  logic [32:0] trial_rem;
  logic [33:0] trial_sub;
  assign trial_rem = {drem_q[31:0], dnum_q[63]};
  assign trial_sub = {1'b0, trial_rem} - {2'b00, abs_diag};

  // saturating subtract of the registered product
  logic signed [63:0] diff;
  logic               ovf;
  assign diff = sum_q - prod_q;
  assign ovf  = (sum_q[63] != prod_q[63]) && (diff[63] != sum_q[63]);

  // read the held neighbor row so the address stays put after acceptance
  snfs_ram #(.Width(32), .Depth(MaxRows)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (row_q),
    .wdata_i (sol_q),
    .raddr_i (nb_q),
    .rdata_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == 1'b0) state_d = row_last_i ? ST_DIV : ST_IDLE;
          else if (!open_q) state_d = ST_IDLE;
          else if (terms_q >= TermW'(MaxTerms - 1) || neighbor_row_i >= 12'(row_q))
            state_d = row_last_i ? ST_DIV : ST_IDLE;
          else state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (dcnt_q == 7'd65) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // write the store on the output step
  always_comb begin
    store_we = (state_q == ST_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rows_cfg_q <= 13'(MaxRows);
      row_q      <= '0;
      sum_q      <= '0;
      diag_q     <= '0;
      terms_q    <= '0;
      open_q     <= 1'b0;
      fault_q    <= ERR_NONE;
      ovalid_q   <= 1'b0;
      last_q     <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) rows_cfg_q <= cfg_wdata_i;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= row_last_i;
            cf_q   <= coeff_i;
            nb_q   <= neighbor_row_i[RowW-1:0];
            dcnt_q <= '0;
            if (func_i == 1'b0) begin
              if (open_q && fault_q == ERR_NONE) fault_q <= ERR_ORDER;
              sum_q   <= 64'(rhs_value_i) <<< FracBits;
              diag_q  <= coeff_i;
              terms_q <= '0;
              open_q  <= 1'b1;
            end else if (!open_q) begin
              // stray term: if it ends a row, report an order error; row state is untouched
              if (row_last_i) begin
                ovalid_q     <= 1'b1;
                orow_q       <= row_q;
                sol_q        <= '0;
                done_q       <= 1'b0;
                oerr_q       <= ERR_ORDER;
              end
            end else if (terms_q >= TermW'(MaxTerms - 1)) begin
              if (fault_q == ERR_NONE) fault_q <= ERR_TOO_MANY;
            end else if (neighbor_row_i >= 12'(row_q)) begin
              terms_q <= terms_q + 1'b1;
              if (fault_q == ERR_NONE) fault_q <= ERR_UNSOLVED;
            end else begin
              terms_q <= terms_q + 1'b1;
            end
          end
        end
        ST_READ: ;
        ST_MUL:  prod_q <= 64'(cf_q) * 64'($signed(rd_data));
        ST_ACC: begin
          sum_q <= ovf ? (sum_q[63] ? S64Min : S64Max) : diff;
        end
        ST_DIV: begin
          if (dcnt_q == 7'd0) begin
            dnum_q <= sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
            dneg_q <= sum_q[63] != diag_q[31];
            drem_q <= '0;
            dquo_q <= '0;
          end else begin
            dnum_q <= {dnum_q[62:0], 1'b0};
            if (!trial_sub[33]) begin
              drem_q <= trial_sub[32:0];
              dquo_q <= {dquo_q[62:0], 1'b1};
            end else begin
              drem_q <= trial_rem;
              dquo_q <= {dquo_q[62:0], 1'b0};
            end
          end
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 7'd65) begin
            // saturate and sign the quotient
            if (diag_q == 32'sd0) sol_q <= '0;
            else if (dneg_q)
              sol_q <= (dquo_q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-dquo_q);
            else
              sol_q <= (dquo_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dquo_q[31:0];
          end
        end
        ST_OUT: begin
          ovalid_q <= 1'b1;
          orow_q   <= row_q;
          done_q   <= (13'(row_q) + 13'd1 >= rows_eff);
          oerr_q   <= (diag_q == 32'sd0 && fault_q == ERR_NONE) ? ERR_ZERO_DIAG
                                                                : fault_q;
          row_q    <= (13'(row_q) + 13'd1 >= rows_eff) ? '0 : row_q + 1'b1;
          sum_q    <= '0;
          diag_q   <= '0;
          terms_q  <= '0;
          open_q   <= 1'b0;
          fault_q  <= ERR_NONE;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = ovalid_q;
  assign row_index_o  = 12'(orow_q);
  assign solution_o   = sol_q;
  assign solve_done_o = done_q;
  assign error_code_o = oerr_q;

`ifndef SYNTHESIS
  // a held result blocks new words
  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("word accepted with result pending");
  // divider runs its full count before leaving
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && state_d == ST_OUT) |-> dcnt_q == 7'd65)
    else $error("divider left early");
  // store is written only as a result is raised
  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |=> out_valid_o) else $error("store write without result");
`endif

endmodule
